@@ rtl/riot_pkg.sv @@
// shared types, op codes and constants for the port and interval timer block
`default_nettype none
package riot_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] SEL_A_DATA = 2'd0;
	localparam logic [1:0] SEL_A_DIR  = 2'd1;
	localparam logic [1:0] SEL_B_DATA = 2'd2;
	localparam logic [1:0] SEL_B_DIR  = 2'd3;

	localparam int TICKS_W = 19;
	localparam logic [7:0] POST_START  = 8'hff;
	localparam logic [7:0] STATUS_FLAG = 8'h80;

	// one accepted transaction, decoded
	typedef struct packed {
		logic       rd;
		logic       wr;
		logic       tick;
		logic [3:0] offset;
		logic [7:0] data;
	} riot_req_t;

	// prescaler select to shift amount: divide by 1, 8, 64, 1024
	function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
		logic [3:0] s;
		case (sel)
			2'd0: s = 4'd0;
			2'd1: s = 4'd3;
			2'd2: s = 4'd6;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

@@ rtl/riot_ports.sv @@
// port a and b data latches and direction registers with read mux
`default_nettype none
module riot_ports (
	input  logic              clk,
	input  logic              arst_n,
	input  riot_pkg::riot_req_t req,
	input  logic [7:0]        port_a_pins,
	input  logic [7:0]        port_b_pins,
	output logic [7:0]        rd_data,
	output logic [7:0]        a_latch_d,
	output logic [7:0]        a_dir_d,
	output logic [7:0]        b_latch_d,
	output logic [7:0]        b_dir_d
);
	import riot_pkg::*;

	logic [7:0] a_latch_q, a_dir_q, b_latch_q, b_dir_q;
	logic       port_wr;

	assign port_wr = req.wr && !req.offset[2];

	always_comb begin
		a_latch_d = a_latch_q;
		a_dir_d   = a_dir_q;
		b_latch_d = b_latch_q;
		b_dir_d   = b_dir_q;
		if (port_wr) begin
			case (req.offset[1:0])
				SEL_A_DATA: a_latch_d = req.data;
				SEL_A_DIR:  a_dir_d   = req.data;
				SEL_B_DATA: b_latch_d = req.data;
				default:    b_dir_d   = req.data;
			endcase
		end
	end

	// pins where direction is input, latch where output
	always_comb begin
		case (req.offset[1:0])
			SEL_A_DATA: rd_data = (port_a_pins & ~a_dir_q) | (a_latch_q & a_dir_q);
			SEL_A_DIR:  rd_data = a_dir_q;
			SEL_B_DATA: rd_data = (port_b_pins & ~b_dir_q) | (b_latch_q & b_dir_q);
			default:    rd_data = b_dir_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_latch_q <= '0;
			a_dir_q   <= '0;
			b_latch_q <= '0;
			b_dir_q   <= '0;
		end else begin
			a_latch_q <= a_latch_d;
			a_dir_q   <= a_dir_d;
			b_latch_q <= b_latch_d;
			b_dir_q   <= b_dir_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/riot_timer.sv @@
// interval timer: prescaled down counter, flag, post-expiry count, irq enable
`default_nettype none
module riot_timer (
	input  logic              clk,
	input  logic              arst_n,
	input  riot_pkg::riot_req_t req,
	output logic [7:0]        rd_data,
	output logic              irq_d
);
	import riot_pkg::*;

	logic                 flag_q, ien_q, running_q, after_q;
	logic [1:0]           psel_q;
	logic [TICKS_W-1:0]   ticks_q;
	logic [7:0]           post_q;

	logic                 flag_d, ien_d, running_d, after_d;
	logic [1:0]           psel_d;
	logic [TICKS_W-1:0]   ticks_d, ticks_dec, ticks_shifted, ticks_load;
	logic [7:0]           post_d;
	logic                 timer_acc;

	assign timer_acc     = req.offset[2];
	assign ticks_shifted = ticks_q >> prescale_shift(psel_q);
	assign ticks_load    = ({{(TICKS_W-8){1'b0}}, req.data} + {{(TICKS_W-1){1'b0}}, 1'b1})
		<< prescale_shift(req.offset[1:0]);
	assign ticks_dec     = (ticks_q != '0) ? ticks_q - {{(TICKS_W-1){1'b0}}, 1'b1} : '0;

	always_comb begin
		if (!req.offset[0]) begin
			if (after_q)
				rd_data = post_q;
			else if (running_q)
				rd_data = ticks_shifted[7:0];
			else
				rd_data = 8'd0;
		end else begin
			rd_data = flag_q ? STATUS_FLAG : 8'd0;
		end
	end

	always_comb begin
		flag_d    = flag_q;
		ien_d     = ien_q;
		running_d = running_q;
		after_d   = after_q;
		psel_d    = psel_q;
		ticks_d   = ticks_q;
		post_d    = post_q;
		if (req.rd && timer_acc) begin
			ien_d = req.offset[3];
			// count read acknowledges the flag, status read keeps it
			if (!req.offset[0])
				flag_d = 1'b0;
		end else if (req.wr && timer_acc) begin
			ien_d     = req.offset[3];
			flag_d    = 1'b0;
			psel_d    = req.offset[1:0];
			ticks_d   = ticks_load;
			running_d = 1'b1;
			after_d   = 1'b0;
			post_d    = 8'd0;
		end else if (req.tick) begin
			if (after_q) begin
				if (post_q != 8'd0)
					post_d = post_q - 8'd1;
			end else if (running_q) begin
				ticks_d = ticks_dec;
				if (ticks_dec == '0) begin
					flag_d  = 1'b1;
					after_d = 1'b1;
					post_d  = POST_START;
				end
			end
		end
	end

	assign irq_d = ien_d & flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= 1'b0;
			ien_q     <= 1'b0;
			running_q <= 1'b0;
			after_q   <= 1'b0;
			psel_q    <= 2'd0;
			ticks_q   <= '0;
			post_q    <= 8'd0;
		end else begin
			flag_q    <= flag_d;
			ien_q     <= ien_d;
			running_q <= running_d;
			after_q   <= after_d;
			psel_q    <= psel_d;
			ticks_q   <= ticks_d;
			post_q    <= post_d;
		end
	end

	a_after_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		after_q |-> running_q)
		else $error("post-expiry count active without a loaded timer");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(req.wr && timer_acc) |=> (!flag_q && running_q && !after_q))
		else $error("timer load did not restart the counter");

	a_post_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.tick && after_q && post_q != 8'd0) |=> (post_q == $past(post_q) - 8'd1))
		else $error("post-expiry count did not step down");

	a_expire: assert property (@(posedge clk) disable iff (!arst_n)
		(req.tick && running_q && !after_q && ticks_q == {{(TICKS_W-1){1'b0}}, 1'b1})
		|=> (flag_q && after_q && post_q == POST_START))
		else $error("last tick did not expire the timer");

endmodule
`default_nettype wire

@@ rtl/riot_ports_and_interval_timer.sv @@
// top level: 6530-style i/o ports and interval timer with a registered result
// result: the result of a transaction is registered and presented in the cycle after it is accepted
// throughput: one transaction per cycle; in_ready stays high while the result
//   register is empty or being taken, so only a stalled result holds off input
// reset: arst_n asynchronously clears port and timer state and the result valid, not the payload
`default_nettype none
module riot_ports_and_interval_timer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [3:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [7:0] port_a_pins,
	input  logic [7:0] port_b_pins,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       irq_line,
	output logic [7:0] port_a_latch,
	output logic [7:0] port_a_direction,
	output logic [7:0] port_b_latch,
	output logic [7:0] port_b_direction
);
	import riot_pkg::*;

	riot_req_t  req;
	logic       fire;
	logic [7:0] port_rd, timer_rd, rd_mux;
	logic [7:0] a_latch_d, a_dir_d, b_latch_d, b_dir_d;
	logic       irq_d;

	// result register
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       irq_q;
	logic [7:0] a_latch_q, a_dir_q, b_latch_q, b_dir_q;

	// the result register frees up in the same cycle it is taken
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	// decode the transaction; op 3 maps to nothing and leaves port and timer state alone, but still returns a result
	assign req.rd     = fire && (op == OP_READ);
	assign req.wr     = fire && (op == OP_WRITE);
	assign req.tick   = fire && (op == OP_TICK);
	assign req.offset = reg_offset;
	assign req.data   = write_data;

	riot_ports u_ports (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.port_a_pins (port_a_pins),
		.port_b_pins (port_b_pins),
		.rd_data     (port_rd),
		.a_latch_d   (a_latch_d),
		.a_dir_d     (a_dir_d),
		.b_latch_d   (b_latch_d),
		.b_dir_d     (b_dir_d)
	);

	riot_timer u_timer (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (timer_rd),
		.irq_d   (irq_d)
	);

	// offset bit 2 picks the timer over the port registers; writes, ticks and op 3 read 0
	assign rd_mux = (op != OP_READ) ? 8'd0 : (reg_offset[2] ? timer_rd : port_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: post-transaction values of the irq line and port registers
	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= rd_mux;
			irq_q       <= irq_d;
			a_latch_q   <= a_latch_d;
			a_dir_q     <= a_dir_d;
			b_latch_q   <= b_latch_d;
			b_dir_q     <= b_dir_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = read_data_q;
	assign irq_line         = irq_q;
	assign port_a_latch     = a_latch_q;
	assign port_a_direction = a_dir_q;
	assign port_b_latch     = b_latch_q;
	assign port_b_direction = b_dir_q;

endmodule
`default_nettype wire
